>>> rtl/qco_pkg.sv
// Shared constants for the quadrilateral corner ordering block.
package qco_pkg;

    localparam int COORD_WIDTH_DEF = 12;
    localparam int COORD_WIDTH_MIN = 8;
    localparam int COORD_WIDTH_MAX = 16;
    localparam int NUM_CORNERS     = 4;
    localparam int RANK_WIDTH      = $clog2(NUM_CORNERS);

endpackage

>>> rtl/qco_sort4.sv
// First pipeline stage: stable sort of four corners by x, registered.
module qco_sort4 #(
    parameter int COORD_WIDTH = qco_pkg::COORD_WIDTH_DEF
) (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  logic                                           i_en,
    input  logic                                           i_vld,
    input  logic [qco_pkg::NUM_CORNERS-1:0][COORD_WIDTH-1:0] i_x,
    input  logic [qco_pkg::NUM_CORNERS-1:0][COORD_WIDTH-1:0] i_y,
    output logic                                           o_vld,
    output logic [qco_pkg::NUM_CORNERS-1:0][COORD_WIDTH-1:0] o_x,
    output logic [qco_pkg::NUM_CORNERS-1:0][COORD_WIDTH-1:0] o_y
);

    localparam int N  = qco_pkg::NUM_CORNERS;
    localparam int RW = qco_pkg::RANK_WIDTH;

    logic [N-1:0][RW-1:0]          rank;
    logic [N-1:0][COORD_WIDTH-1:0] n_x;
    logic [N-1:0][COORD_WIDTH-1:0] n_y;
    logic                          r_vld;
    logic [N-1:0][COORD_WIDTH-1:0] r_x;
    logic [N-1:0][COORD_WIDTH-1:0] r_y;

    // rank = number of points that land before this one; earlier inputs win ties
    always_comb begin
        for (int i = 0; i < N; i++) begin
            rank[i] = '0;
            for (int j = 0; j < N; j++) begin
                if (j < i && i_x[j] <= i_x[i]) begin
                    rank[i] = rank[i] + RW'(1);
                end else if (j > i && i_x[j] < i_x[i]) begin
                    rank[i] = rank[i] + RW'(1);
                end
            end
        end
    end

    // ranks form a permutation, so an OR of the matches selects one point
    always_comb begin
        for (int k = 0; k < N; k++) begin
            n_x[k] = '0;
            n_y[k] = '0;
            for (int i = 0; i < N; i++) begin
                if (rank[i] == RW'(k)) begin
                    n_x[k] = n_x[k] | i_x[i];
                    n_y[k] = n_y[k] | i_y[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= n_x;
            r_y <= n_y;
        end
    end

    assign o_vld = r_vld;
    assign o_x   = r_x;
    assign o_y   = r_y;

endmodule

>>> rtl/quad_corner_order.sv
// Top level: orders the four corners of a text quadrilateral, six-stage pipeline.
//
// Input channel: i_in_valid / o_in_ready carries four unordered corners per beat.
// Output channel: o_out_valid / i_out_ready carries the ordered corners
// (top-left, top-right, bottom-right, bottom-left), the box center as the sum
// of the four coordinates (quarter pixels) and the left side center as the
// sum of top-left and bottom-left (half pixels).
// Six register stages, the first loaded at the edge that takes the input
// beat: sort by x, pair by y, side deltas, squares, sums of squares,
// compare and rotate. Throughput: one beat per cycle while the output
// is not stalled.
// The whole pipeline advances on one enable: it moves when the output stage
// is empty or its beat is taken. While the receiver stalls with a valid
// output, every stage holds and o_in_ready is low; nothing is lost or doubled.
// Reset (synchronous, active low) clears all stage valid bits; payload
// registers are not reset.
// The block keeps no state between beats.
module quad_corner_order #(
    parameter int COORD_WIDTH = qco_pkg::COORD_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [COORD_WIDTH-1:0] i_pt1_x,
    input  logic [COORD_WIDTH-1:0] i_pt1_y,
    input  logic [COORD_WIDTH-1:0] i_pt2_x,
    input  logic [COORD_WIDTH-1:0] i_pt2_y,
    input  logic [COORD_WIDTH-1:0] i_pt3_x,
    input  logic [COORD_WIDTH-1:0] i_pt3_y,
    input  logic [COORD_WIDTH-1:0] i_pt4_x,
    input  logic [COORD_WIDTH-1:0] i_pt4_y,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [COORD_WIDTH-1:0] o_top_left_x,
    output logic [COORD_WIDTH-1:0] o_top_left_y,
    output logic [COORD_WIDTH-1:0] o_top_right_x,
    output logic [COORD_WIDTH-1:0] o_top_right_y,
    output logic [COORD_WIDTH-1:0] o_bottom_right_x,
    output logic [COORD_WIDTH-1:0] o_bottom_right_y,
    output logic [COORD_WIDTH-1:0] o_bottom_left_x,
    output logic [COORD_WIDTH-1:0] o_bottom_left_y,
    output logic [COORD_WIDTH+1:0] o_center_x_q,
    output logic [COORD_WIDTH+1:0] o_center_y_q,
    output logic [COORD_WIDTH:0]   o_left_mid_x_h,
    output logic [COORD_WIDTH:0]   o_left_mid_y_h
);

    localparam int N  = qco_pkg::NUM_CORNERS;
    localparam int CW = COORD_WIDTH;
    localparam int SW = COORD_WIDTH + 2;
    localparam int HW = COORD_WIDTH + 1;
    localparam int QW = 2 * COORD_WIDTH;
    localparam int DW = 2 * COORD_WIDTH + 1;

    logic                 en;
    logic [N-1:0][CW-1:0] in_x;
    logic [N-1:0][CW-1:0] in_y;

    // stage 1 (sort)
    logic                 s1_vld;
    logic [N-1:0][CW-1:0] s1_x;
    logic [N-1:0][CW-1:0] s1_y;

    // stage 2: corners 0 TL, 1 TR, 2 BR, 3 BL
    logic                 r2_vld;
    logic [N-1:0][CW-1:0] r2_x, r2_y;
    logic [SW-1:0]        r2_cx, r2_cy;
    logic [N-1:0][CW-1:0] n2_x, n2_y;

    // stage 3: side deltas
    logic                 r3_vld;
    logic [N-1:0][CW-1:0] r3_x, r3_y;
    logic [SW-1:0]        r3_cx, r3_cy;
    logic [CW-1:0]        r3_lx, r3_ly, r3_tx, r3_ty;
    logic [CW-1:0]        n3_lx, n3_ly, n3_tx, n3_ty;

    // stage 4: squares and both left-mid candidates
    logic                 r4_vld;
    logic [N-1:0][CW-1:0] r4_x, r4_y;
    logic [SW-1:0]        r4_cx, r4_cy;
    logic [QW-1:0]        r4_lxx, r4_lyy, r4_txx, r4_tyy;
    logic [HW-1:0]        r4_mx_n, r4_my_n, r4_mx_r, r4_my_r;

    // stage 5: squared side lengths
    logic                 r5_vld;
    logic [N-1:0][CW-1:0] r5_x, r5_y;
    logic [SW-1:0]        r5_cx, r5_cy;
    logic [HW-1:0]        r5_mx_n, r5_my_n, r5_mx_r, r5_my_r;
    logic [DW-1:0]        r5_ld, r5_td;

    // stage 6: output
    logic                 r6_vld;
    logic [N-1:0][CW-1:0] r6_x, r6_y;
    logic [SW-1:0]        r6_cx, r6_cy;
    logic [HW-1:0]        r6_mx, r6_my;
    logic                 n6_rot;
    logic [N-1:0][CW-1:0] n6_x, n6_y;

    assign en         = !r6_vld || i_out_ready;
    assign o_in_ready = en;

    assign in_x[0] = i_pt1_x;
    assign in_y[0] = i_pt1_y;
    assign in_x[1] = i_pt2_x;
    assign in_y[1] = i_pt2_y;
    assign in_x[2] = i_pt3_x;
    assign in_y[2] = i_pt3_y;
    assign in_x[3] = i_pt4_x;
    assign in_y[3] = i_pt4_y;

    qco_sort4 #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_sort (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (i_in_valid),
        .i_x     (in_x),
        .i_y     (in_y),
        .o_vld   (s1_vld),
        .o_x     (s1_x),
        .o_y     (s1_y)
    );

    // pair left and right columns by y; tie keeps sorted order
    always_comb begin
        if (s1_y[0] <= s1_y[1]) begin
            n2_x[0] = s1_x[0]; n2_y[0] = s1_y[0];
            n2_x[3] = s1_x[1]; n2_y[3] = s1_y[1];
        end else begin
            n2_x[0] = s1_x[1]; n2_y[0] = s1_y[1];
            n2_x[3] = s1_x[0]; n2_y[3] = s1_y[0];
        end
        if (s1_y[2] <= s1_y[3]) begin
            n2_x[1] = s1_x[2]; n2_y[1] = s1_y[2];
            n2_x[2] = s1_x[3]; n2_y[2] = s1_y[3];
        end else begin
            n2_x[1] = s1_x[3]; n2_y[1] = s1_y[3];
            n2_x[2] = s1_x[2]; n2_y[2] = s1_y[2];
        end
    end

    always_comb begin
        n3_lx = (r2_x[0] > r2_x[3]) ? r2_x[0] - r2_x[3] : r2_x[3] - r2_x[0];
        n3_ly = (r2_y[0] > r2_y[3]) ? r2_y[0] - r2_y[3] : r2_y[3] - r2_y[0];
        n3_tx = (r2_x[0] > r2_x[1]) ? r2_x[0] - r2_x[1] : r2_x[1] - r2_x[0];
        n3_ty = (r2_y[0] > r2_y[1]) ? r2_y[0] - r2_y[1] : r2_y[1] - r2_y[0];
    end

    // rotate when the left side is strictly longer than the top side
    always_comb begin
        n6_rot = r5_ld > r5_td;
        if (n6_rot) begin
            n6_x[0] = r5_x[3]; n6_y[0] = r5_y[3];
            n6_x[1] = r5_x[0]; n6_y[1] = r5_y[0];
            n6_x[2] = r5_x[1]; n6_y[2] = r5_y[1];
            n6_x[3] = r5_x[2]; n6_y[3] = r5_y[2];
        end else begin
            n6_x = r5_x;
            n6_y = r5_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
            r6_vld <= 1'b0;
        end else if (en) begin
            r2_vld <= s1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
            r6_vld <= r5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_x  <= n2_x;
            r2_y  <= n2_y;
            r2_cx <= SW'(s1_x[0]) + SW'(s1_x[1]) + SW'(s1_x[2]) + SW'(s1_x[3]);
            r2_cy <= SW'(s1_y[0]) + SW'(s1_y[1]) + SW'(s1_y[2]) + SW'(s1_y[3]);

            r3_x  <= r2_x;
            r3_y  <= r2_y;
            r3_cx <= r2_cx;
            r3_cy <= r2_cy;
            r3_lx <= n3_lx;
            r3_ly <= n3_ly;
            r3_tx <= n3_tx;
            r3_ty <= n3_ty;

            r4_x    <= r3_x;
            r4_y    <= r3_y;
            r4_cx   <= r3_cx;
            r4_cy   <= r3_cy;
            r4_lxx  <= QW'(r3_lx) * QW'(r3_lx);
            r4_lyy  <= QW'(r3_ly) * QW'(r3_ly);
            r4_txx  <= QW'(r3_tx) * QW'(r3_tx);
            r4_tyy  <= QW'(r3_ty) * QW'(r3_ty);
            r4_mx_n <= HW'(r3_x[0]) + HW'(r3_x[3]);
            r4_my_n <= HW'(r3_y[0]) + HW'(r3_y[3]);
            r4_mx_r <= HW'(r3_x[3]) + HW'(r3_x[2]);
            r4_my_r <= HW'(r3_y[3]) + HW'(r3_y[2]);

            r5_x    <= r4_x;
            r5_y    <= r4_y;
            r5_cx   <= r4_cx;
            r5_cy   <= r4_cy;
            r5_mx_n <= r4_mx_n;
            r5_my_n <= r4_my_n;
            r5_mx_r <= r4_mx_r;
            r5_my_r <= r4_my_r;
            r5_ld   <= DW'(r4_lxx) + DW'(r4_lyy);
            r5_td   <= DW'(r4_txx) + DW'(r4_tyy);

            r6_x  <= n6_x;
            r6_y  <= n6_y;
            r6_cx <= r5_cx;
            r6_cy <= r5_cy;
            r6_mx <= n6_rot ? r5_mx_r : r5_mx_n;
            r6_my <= n6_rot ? r5_my_r : r5_my_n;
        end
    end

    assign o_out_valid      = r6_vld;
    assign o_top_left_x     = r6_x[0];
    assign o_top_left_y     = r6_y[0];
    assign o_top_right_x    = r6_x[1];
    assign o_top_right_y    = r6_y[1];
    assign o_bottom_right_x = r6_x[2];
    assign o_bottom_right_y = r6_y[2];
    assign o_bottom_left_x  = r6_x[3];
    assign o_bottom_left_y  = r6_y[3];
    assign o_center_x_q     = r6_cx;
    assign o_center_y_q     = r6_cy;
    assign o_left_mid_x_h   = r6_mx;
    assign o_left_mid_y_h   = r6_my;

`ifndef ASSERT_OFF
    // center is the plain sum of the emitted corners, whatever the rotation
    a_center_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_center_x_q == SW'(o_top_left_x) + SW'(o_top_right_x)
                         + SW'(o_bottom_right_x) + SW'(o_bottom_left_x)))
        else $error("center x does not match emitted corners");

    // left mid must follow the rotated corners, not the paired ones
    a_left_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_left_mid_x_h == HW'(o_top_left_x) + HW'(o_bottom_left_x)
                         && o_left_mid_y_h == HW'(o_top_left_y) + HW'(o_bottom_left_y)))
        else $error("left mid does not match emitted corners");

    // a stalled output beat freezes the whole pipe
    a_stall_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input accepted while output stalled");
`endif

endmodule
